// ===== rtl/tssh_pkg.sv =====
// Shared types and constants for the threshold-switched sample and hold.
`default_nettype none

package tssh_pkg;

	// Voltages: signed fixed point, 10 fractional bits (1 V = 1024)
	typedef logic signed [14:0] volt_t;
	typedef logic [15:0]        ticks_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_THRESHOLD_LEVEL = 3'd0,
		REG_SCALE_A         = 3'd1,
		REG_SCALE_B         = 3'd2,
		REG_OFFSET_A        = 3'd3,
		REG_OFFSET_B        = 3'd4,
		REG_MODE_A          = 3'd5,
		REG_MODE_B          = 3'd6,
		REG_PULSE_TICKS     = 3'd7
	} cfg_reg_t;

	// Active set codes
	typedef enum logic [1:0] {
		SET_NONE = 2'd0,
		SET_A    = 2'd1,
		SET_B    = 2'd2
	} set_sel_t;

	localparam volt_t  SCHMITT_ON  = 15'sd1024;
	localparam volt_t  SCHMITT_OFF = 15'sd0;
	localparam volt_t  OUT_MIN     = -15'sd12288;
	localparam volt_t  OUT_MAX     = 15'sd12287;
	localparam int     FRAC_BITS   = 10;
	localparam logic signed [32:0] ROUND_HALF = 33'sd512;

	localparam volt_t  RST_THRESHOLD = 15'sd0;
	localparam volt_t  RST_SCALE     = 15'sd1024;
	localparam volt_t  RST_OFFSET    = 15'sd0;
	localparam ticks_t RST_PULSE     = 16'd48;

	// One input beat as held in the input register
	typedef struct packed {
		volt_t trig_level;
		logic  trig_connected;
		logic  button;
		volt_t source_cv;
		volt_t threshold_cv;
		logic  threshold_connected;
		volt_t mod_cv_a;
		volt_t mod_cv_b;
	} in_item_t;

endpackage

`default_nettype wire

// ===== rtl/threshold_switched_sample_hold_top.sv =====
// Top level of the threshold-switched sample and hold.
`default_nettype none

// Threshold-switched sample and hold. Each input beat is one tick. A Schmitt
// trigger on trig_level (high at >= 1 V, low at <= 0 V) or a rising edge of
// button takes one sample of source_cv while the trigger input is patched;
// with it unpatched the held sample tracks source_cv. Whenever the held sample
// changes it is compared with the threshold (threshold_cv when patched, else
// the threshold_level register): strictly above selects set A, otherwise set
// B. cv_out is then (sample + mod_cv + offset) * scale in modify mode, or
// (mod_cv + offset) * scale in replace mode, rounded half up and saturated to
// +/-12 V, and held until the next change. Switching set fires that set's
// trigger output for the firing tick plus pulse_ticks further ticks.
// Timing: one beat per cycle sustained while out_ready stays high; a result
// passes from its input beat through the input register, then the single
// compare/add/multiply stage into the result register. The block holds at
// most two beats: once both registers are full, in_ready follows out_ready
// in the same cycle, so from empty at most two beats are taken while
// out_ready stays low. Configuration writes are always accepted (cfg_ready
// tied high) and must only be issued while the block is idle.
module threshold_switched_sample_hold_top (
	input  logic                  clk,
	input  logic                  arst_n,
	// input beats
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tssh_pkg::volt_t       trig_level,
	input  logic                  trig_connected,
	input  logic                  button,
	input  tssh_pkg::volt_t       source_cv,
	input  tssh_pkg::volt_t       threshold_cv,
	input  logic                  threshold_connected,
	input  tssh_pkg::volt_t       mod_cv_a,
	input  tssh_pkg::volt_t       mod_cv_b,
	// result beats
	output logic                  out_valid,
	input  logic                  out_ready,
	output tssh_pkg::volt_t       cv_out,
	output logic                  trig_a,
	output logic                  trig_b,
	output logic [1:0]            active_set,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data
);
	import tssh_pkg::*;

	// Configuration registers
	volt_t  threshold_level_q;
	volt_t  scale_a_q, scale_b_q;
	volt_t  offset_a_q, offset_b_q;
	logic   mode_a_q, mode_b_q;
	ticks_t pulse_ticks_q;

	// Tick state
	logic     schmitt_q, button_prev_q, ready_q;
	volt_t    held_q, prev_sample_q, out_hold_q;
	set_sel_t last_set_q;
	ticks_t   pulse_q [2];

	// Input register
	in_item_t in_s1;
	logic     valid_s1;

	// Result register
	volt_t    cv_out_q;
	logic     trig_a_q, trig_b_q;
	set_sel_t active_set_q;
	logic     out_valid_q;

	logic advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_level_q <= RST_THRESHOLD;
			scale_a_q         <= RST_SCALE;
			scale_b_q         <= RST_SCALE;
			offset_a_q        <= RST_OFFSET;
			offset_b_q        <= RST_OFFSET;
			mode_a_q          <= 1'b0;
			mode_b_q          <= 1'b0;
			pulse_ticks_q     <= RST_PULSE;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD_LEVEL: threshold_level_q <= cfg_data[14:0];
				REG_SCALE_A:         scale_a_q         <= cfg_data[14:0];
				REG_SCALE_B:         scale_b_q         <= cfg_data[14:0];
				REG_OFFSET_A:        offset_a_q        <= cfg_data[14:0];
				REG_OFFSET_B:        offset_b_q        <= cfg_data[14:0];
				REG_MODE_A:          mode_a_q          <= cfg_data[0];
				REG_MODE_B:          mode_b_q          <= cfg_data[0];
				REG_PULSE_TICKS:     pulse_ticks_q     <= cfg_data;
				default:             ;
			endcase
		end
	end

	// Input stage moves on when the result slot is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= '{trig_level, trig_connected, button, source_cv,
				threshold_cv, threshold_connected, mod_cv_a, mod_cv_b};
		end
	end

	// Tick logic
	volt_t    trig_eff, thr, cv_sel, scale_sel, offset_sel;
	logic     schmitt_nx, trig_edge, press, sample_take;
	volt_t    held_nx, out_hold_nx;
	logic     changed, sel_b, replace_sel, fire;
	set_sel_t new_set, last_set_nx;
	logic     tout_pre [2];
	logic     tout [2];
	ticks_t   pulse_nx [2];
	logic signed [16:0] sum;
	logic signed [31:0] prod;
	logic signed [32:0] rounded;
	logic signed [22:0] scaled;

	always_comb begin
		trig_eff = in_s1.trig_connected ? in_s1.trig_level : SCHMITT_OFF;

		// Schmitt trigger; the rising transition is the sampling edge
		if (schmitt_q) begin
			schmitt_nx = !(trig_eff <= SCHMITT_OFF);
		end else begin
			schmitt_nx = (trig_eff >= SCHMITT_ON);
		end
		trig_edge = !schmitt_q && schmitt_nx;
		press     = in_s1.button && !button_prev_q;

		sample_take = ready_q && (trig_edge || press);
		if (!in_s1.trig_connected || sample_take) begin
			held_nx = in_s1.source_cv;
		end else begin
			held_nx = held_q;
		end

		changed = (held_nx != prev_sample_q);
		thr     = in_s1.threshold_connected ? in_s1.threshold_cv : threshold_level_q;
		sel_b   = !(held_nx > thr);
		new_set = sel_b ? SET_B : SET_A;

		cv_sel      = sel_b ? in_s1.mod_cv_b : in_s1.mod_cv_a;
		scale_sel   = sel_b ? scale_b_q      : scale_a_q;
		offset_sel  = sel_b ? offset_b_q     : offset_a_q;
		replace_sel = sel_b ? mode_b_q       : mode_a_q;

		sum = 17'(cv_sel) + 17'(offset_sel) + (replace_sel ? 17'sd0 : 17'(held_nx));
		prod    = 32'(sum) * 32'(scale_sel);
		rounded = 33'(prod) + ROUND_HALF;
		scaled  = 23'(rounded >>> FRAC_BITS);

		// saturate to +/-12 V
		if (scaled < 23'(OUT_MIN)) begin
			out_hold_nx = OUT_MIN;
		end else if (scaled > 23'(OUT_MAX)) begin
			out_hold_nx = OUT_MAX;
		end else begin
			out_hold_nx = scaled[14:0];
		end
		if (!changed) begin
			out_hold_nx = out_hold_q;
		end

		fire        = changed && (last_set_q != new_set);
		last_set_nx = changed ? new_set : last_set_q;

		for (int k = 0; k < 2; k++) begin
			tout_pre[k] = (pulse_q[k] != '0);
			pulse_nx[k] = tout_pre[k] ? pulse_q[k] - 16'd1 : pulse_q[k];
			tout[k]     = tout_pre[k];
			if (fire && (sel_b == k[0])) begin
				pulse_nx[k] = pulse_ticks_q;
				tout[k]     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			schmitt_q     <= 1'b0;
			button_prev_q <= 1'b0;
			ready_q       <= 1'b1;
			held_q        <= '0;
			prev_sample_q <= '0;
			out_hold_q    <= '0;
			last_set_q    <= SET_NONE;
			pulse_q[0]    <= '0;
			pulse_q[1]    <= '0;
		end else if (advance) begin
			schmitt_q     <= schmitt_nx;
			button_prev_q <= in_s1.button;
			ready_q       <= !schmitt_nx;
			held_q        <= held_nx;
			prev_sample_q <= held_nx;
			out_hold_q    <= out_hold_nx;
			last_set_q    <= last_set_nx;
			pulse_q[0]    <= pulse_nx[0];
			pulse_q[1]    <= pulse_nx[1];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cv_out_q     <= out_hold_nx;
			trig_a_q     <= tout[0];
			trig_b_q     <= tout[1];
			active_set_q <= last_set_nx;
		end
	end

	assign out_valid  = out_valid_q;
	assign cv_out     = cv_out_q;
	assign trig_a     = trig_a_q;
	assign trig_b     = trig_b_q;
	assign active_set = active_set_q;

endmodule

`default_nettype wire

// ===== rtl/tssh_checker.sv =====
// Port-level checker for the threshold-switched sample and hold, with its bind.
`default_nettype none

module tssh_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input tssh_pkg::volt_t       cv_out,
	input logic                  trig_a,
	input logic                  trig_b,
	input logic [1:0]            active_set
);
	import tssh_pkg::*;

	// once a set has been chosen the block never returns to none
	logic seen_set_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_set_q <= 1'b0;
		end else if (out_valid && out_ready && (active_set != SET_NONE)) begin
			seen_set_q <= 1'b1;
		end
	end

	a_set_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (active_set == SET_NONE || active_set == SET_A ||
			active_set == SET_B))
		else $error("active_set carries an unused code");

	a_set_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && seen_set_q) |-> (active_set != SET_NONE))
		else $error("active_set fell back to none");

	a_no_set_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !seen_set_q && active_set == SET_NONE) |-> (!trig_a && !trig_b))
		else $error("set trigger high before any set was chosen");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(cv_out) &&
			$stable(trig_a) && $stable(trig_b) && $stable(active_set)))
		else $error("result beat changed while stalled");

endmodule

bind threshold_switched_sample_hold_top tssh_checker u_tssh_checker (.*);

`default_nettype wire
